@@ rtl/core/crx_pkg.sv @@
package crx_pkg;

    // field widths
    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int FLEN_W     = 6;
    localparam int PLEN_W     = 5;
    localparam int TIMER_W    = 16;
    localparam int SUM_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // frame handling constants
    localparam int FRAME_CEILING = 32;
    localparam int CHECK_MIN     = 3;
    localparam int QUEUE_DEPTH   = 2;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 2'd3;

    // register reset values
    localparam logic [FLEN_W-1:0]  RST_MAX_FRAME  = 6'd20;
    localparam logic [TIMER_W-1:0] RST_FIRST_WAIT = 16'd1000;
    localparam logic [TIMER_W-1:0] RST_BYTE_GAP   = 16'd50;
    localparam logic [BYTE_W-1:0]  RST_DELIMITER  = 8'd124;

    // frame job passed from the front to the back
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FLEN_W-1:0]   flen;
        logic [PLEN_W-1:0]   plen;
    } t_job;

    // frame buffer write
    typedef struct packed {
        logic              en;
        logic [FLEN_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_buf_wr;

endpackage

@@ rtl/core/crx_in_if.sv @@
interface crx_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink (input valid, input func, input data_byte, output ready);
endinterface

@@ rtl/core/crx_out_if.sv @@
interface crx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] payload_byte;
    logic       last;
    logic [5:0] frame_length;
    logic [4:0] payload_length;

    modport source (output valid, output status, output payload_byte, output last,
                    output frame_length, output payload_length, input ready);
    modport sink (input valid, input status, input payload_byte, input last,
                  input frame_length, input payload_length, output ready);
endinterface

@@ rtl/core/checksum_frame_receiver_top.sv @@
// a status result (empty, timeout, overflow) passes the job queue and the output register;
// a payload passes the queue, drain sequencer, buffer read and output register, then 1 byte
// a cycle while the output is ready; throughput: 1 item per cycle, set by the combinational
// front sum/compare; new items wait while the queue is full or until the last buffer read
// of a pending payload; reset: synchronous, active low; clears session, timer, job queue and
// output, restores register defaults; frame buffer contents are left as they are
module checksum_frame_receiver_top #(
    parameter int MAX_BYTES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [crx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    crx_in_if.sink                         i_in,
    crx_out_if.source                      o_out
);
    import crx_pkg::*;

    t_job    push_job;
    t_job    q_job;
    t_buf_wr buf_wr;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    logic    release_lock;

    // item intake and frame check
    crx_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .i_release  (release_lock),
        .o_push     (push),
        .o_job      (push_job),
        .o_buf_wr   (buf_wr)
    );

    // job queue between front and back
    crx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // result generation and payload drain
    crx_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_buf_wr  (buf_wr),
        .i_q_empty (q_empty),
        .i_q_job   (q_job),
        .o_q_pop   (pop),
        .o_release (release_lock),
        .o_out     (o_out)
    );

endmodule

@@ rtl/core/crx_front.sv @@
module crx_front #(
    parameter int MAX_BYTES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [crx_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [crx_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    crx_in_if.sink                              i_in,
    input  logic                                i_q_full,
    input  logic                                i_release,
    output logic                                o_push,
    output crx_pkg::t_job                       o_job,
    output crx_pkg::t_buf_wr                    o_buf_wr
);
    import crx_pkg::*;

    localparam logic [FLEN_W:0] LIMIT_CAP =
        (FLEN_W + 1)'((MAX_BYTES < FRAME_CEILING) ? MAX_BYTES : FRAME_CEILING);
    localparam logic [FLEN_W:0] BUF_DEPTH = (FLEN_W + 1)'(MAX_BYTES);

    // configuration registers
    logic [FLEN_W-1:0]  r_max_frame;
    logic [TIMER_W-1:0] r_first_wait;
    logic [TIMER_W-1:0] r_byte_gap;
    logic [BYTE_W-1:0]  r_delim;

    // session state
    logic               r_active, n_active;
    logic [FLEN_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [23:0]        r_tail, n_tail;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_lock, n_lock;

    logic               accept;
    logic [FLEN_W-1:0]  new_count;
    logic [SUM_W-1:0]   new_sum;
    logic [23:0]        new_tail;
    logic               match;
    logic [FLEN_W:0]    cfg_lim;
    logic [FLEN_W:0]    limit;
    logic               over;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_lock && !i_q_full;

    // byte datapath: running sum, tail shift and frame check
    always_comb begin
        new_count = r_count + FLEN_W'(1);
        new_tail  = {r_tail[15:0], i_in.data_byte};
        if (r_count >= FLEN_W'(CHECK_MIN)) begin
            new_sum = r_sum + {8'd0, r_tail[23:16]};
        end else begin
            new_sum = r_sum;
        end
        match = (new_count >= FLEN_W'(CHECK_MIN)) && (new_tail[23:16] == r_delim)
                && (new_tail[15:0] == new_sum);
        cfg_lim = {1'b0, r_max_frame};
        limit   = (cfg_lim > LIMIT_CAP) ? LIMIT_CAP : cfg_lim;
        over    = {1'b0, new_count} >= limit;
    end

    // item classification and session update
    always_comb begin
        n_active = r_active;
        n_count  = r_count;
        n_sum    = r_sum;
        n_tail   = r_tail;
        n_timer  = r_timer;
        o_push   = 1'b0;
        o_job    = '0;
        o_buf_wr.en   = 1'b0;
        o_buf_wr.addr = r_count;
        o_buf_wr.data = i_in.data_byte;
        if (accept) begin
            unique case (i_in.func)
                FUNC_START: begin
                    n_active = 1'b1;
                    n_count  = '0;
                    n_sum    = '0;
                    n_tail   = '0;
                    n_timer  = r_first_wait;
                end
                FUNC_BYTE: begin
                    if (r_active) begin
                        o_buf_wr.en = {1'b0, r_count} < BUF_DEPTH;
                        n_count = new_count;
                        n_sum   = new_sum;
                        n_tail  = new_tail;
                        if (match) begin
                            n_active    = 1'b0;
                            o_push      = 1'b1;
                            o_job.flen  = new_count;
                            o_job.plen  = PLEN_W'(new_count - FLEN_W'(CHECK_MIN));
                            o_job.status = (new_count == FLEN_W'(CHECK_MIN)) ?
                                           ST_EMPTY : ST_PAYLOAD;
                        end else if (over) begin
                            n_active     = 1'b0;
                            o_push       = 1'b1;
                            o_job.status = ST_OVERFLOW;
                            o_job.flen   = new_count;
                        end else begin
                            n_timer = r_byte_gap;
                        end
                    end
                end
                FUNC_TICK: begin
                    if (r_active) begin
                        if (r_timer <= TIMER_W'(1)) begin
                            n_active     = 1'b0;
                            n_timer      = '0;
                            o_push       = 1'b1;
                            o_job.status = ST_TIMEOUT;
                            o_job.flen   = r_count;
                        end else begin
                            n_timer = r_timer - TIMER_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // hold off new items while a payload waits in or drains from the buffer
    always_comb begin
        n_lock = r_lock;
        priority if (o_push && o_job.status == ST_PAYLOAD) begin
            n_lock = 1'b1;
        end else if (i_release) begin
            n_lock = 1'b0;
        end
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_count      <= '0;
            r_sum        <= '0;
            r_tail       <= '0;
            r_timer      <= '0;
            r_lock       <= 1'b0;
            r_max_frame  <= RST_MAX_FRAME;
            r_first_wait <= RST_FIRST_WAIT;
            r_byte_gap   <= RST_BYTE_GAP;
            r_delim      <= RST_DELIMITER;
        end else begin
            r_active <= n_active;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_tail   <= n_tail;
            r_timer  <= n_timer;
            r_lock   <= n_lock;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_FRAME:  r_max_frame  <= i_cfg_data[FLEN_W-1:0];
                    CFG_FIRST_WAIT: r_first_wait <= i_cfg_data[TIMER_W-1:0];
                    CFG_BYTE_GAP:   r_byte_gap   <= i_cfg_data[TIMER_W-1:0];
                    CFG_DELIMITER:  r_delim      <= i_cfg_data[BYTE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // a payload job always counts delimiter and checksum on top of the payload
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_job.status == ST_PAYLOAD |->
            o_job.plen != '0 && o_job.flen == FLEN_W'(o_job.plen) + FLEN_W'(CHECK_MIN))
        else $error("payload job lengths inconsistent");

    // no byte may land in the buffer while a payload is still pending
    a_lock_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> !o_buf_wr.en && !o_push)
        else $error("buffer touched while payload pending");

endmodule

@@ rtl/core/crx_fifo.sv @@
module crx_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  crx_pkg::t_job i_job,
    input  logic          i_pop,
    output crx_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import crx_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // queue never overruns or underruns
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push |-> !o_full) and (i_pop |-> !o_empty))
        else $error("job queue overrun or underrun");

endmodule

@@ rtl/core/crx_back.sv @@
module crx_back #(
    parameter int MAX_BYTES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  crx_pkg::t_buf_wr i_buf_wr,
    input  logic             i_q_empty,
    input  crx_pkg::t_job    i_q_job,
    output logic             o_q_pop,
    output logic             o_release,
    crx_out_if.source        o_out
);
    import crx_pkg::*;

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    // frame buffer
    logic [BYTE_W-1:0] r_mem [MAX_BYTES];
    logic [BYTE_W-1:0] r_rd_data;

    // drain sequencer
    logic              r_busy;
    logic [AW-1:0]     r_idx;
    logic [PLEN_W-1:0] r_plen;
    logic [FLEN_W-1:0] r_flen;
    logic              r_s1_v;
    logic              r_s1_last;

    // output register
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [BYTE_W-1:0]   r_o_byte;
    logic                r_o_last;
    logic [FLEN_W-1:0]   r_o_flen;
    logic [PLEN_W-1:0]   r_o_plen;

    logic adv;
    logic issue;
    logic last_issue;

    assign adv        = !r_o_valid || o_out.ready;
    assign o_q_pop    = !r_busy && !r_s1_v && adv && !i_q_empty;
    assign issue      = r_busy && (!r_s1_v || adv);
    assign last_issue = (7'(r_idx) + 7'd1) == 7'(r_plen);
    assign o_release  = issue && last_issue;

    assign o_out.valid          = r_o_valid;
    assign o_out.status         = r_o_status;
    assign o_out.payload_byte   = r_o_byte;
    assign o_out.last           = r_o_last;
    assign o_out.frame_length   = r_o_flen;
    assign o_out.payload_length = r_o_plen;

    // buffer write from the front, registered read for the drain
    always_ff @(posedge i_clk) begin
        if (i_buf_wr.en) begin
            r_mem[i_buf_wr.addr[AW-1:0]] <= i_buf_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // job pickup and payload read sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_s1_v    <= 1'b0;
            r_idx     <= '0;
            r_s1_last <= 1'b0;
        end else begin
            if (o_q_pop && i_q_job.status == ST_PAYLOAD) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (issue) begin
                r_idx <= r_idx + AW'(1);
                if (last_issue) begin
                    r_busy <= 1'b0;
                end
            end
            if (issue) begin
                r_s1_v    <= 1'b1;
                r_s1_last <= last_issue;
            end else if (adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    // lengths of the frame being drained
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_plen <= i_q_job.plen;
            r_flen <= i_q_job.flen;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            if (r_s1_v) begin
                r_o_valid <= 1'b1;
            end else if (o_q_pop && i_q_job.status != ST_PAYLOAD) begin
                r_o_valid <= 1'b1;
            end else begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s1_v) begin
                r_o_status <= ST_PAYLOAD;
                r_o_byte   <= r_rd_data;
                r_o_last   <= r_s1_last;
                r_o_flen   <= r_flen;
                r_o_plen   <= r_plen;
            end else begin
                r_o_status <= i_q_job.status;
                r_o_byte   <= '0;
                r_o_last   <= 1'b1;
                r_o_flen   <= i_q_job.flen;
                r_o_plen   <= '0;
            end
        end
    end

    // status-only results close their run at once
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != ST_PAYLOAD |->
            o_out.last && o_out.payload_byte == '0 && o_out.payload_length == '0)
        else $error("status result malformed");

    // a drain never overlaps with picking up the next job
    a_drain_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy || r_s1_v) |-> !o_q_pop)
        else $error("job popped during payload drain");

endmodule
